[rtl/smx_pkg.sv]
// Shared types, constants and a helper function for the stereo mix accumulator.
package smx_pkg;

    // Field widths fixed by the command and result formats.
    localparam int SLOT_W   = 11;
    localparam int SAMPLE_W = 16;
    localparam int CHVOL_W  = 8;
    localparam int MVOL_W   = 9;
    localparam int VOL_W    = 9;
    localparam int PROD_W   = SAMPLE_W + VOL_W + 1;
    localparam int ACC_W    = 32;
    localparam int PCM_W    = 16;
    localparam int VOL_SHIFT = 8;
    localparam int PCM_SHIFT = 8;

    // Master volume after reset: unity gain in Q8.
    localparam logic [MVOL_W-1:0] MASTER_VOL_RESET = 9'd256;

    // Saturation limits of the PCM output, held at the width of the shifted accumulator.
    localparam int SHIFTED_W = ACC_W - PCM_SHIFT;
    localparam logic signed [SHIFTED_W-1:0] SAT_HI = 24'sd32767;
    localparam logic signed [SHIFTED_W-1:0] SAT_LO = -24'sd32768;
    localparam logic signed [PCM_W-1:0]     PCM_MAX = 16'sh7FFF;
    localparam logic signed [PCM_W-1:0]     PCM_MIN = 16'sh8000;

    // Command queue between the front and back ends.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Command codes.
    typedef enum logic {
        KIND_ACCUM = 1'b0,
        KIND_DRAIN = 1'b1
    } smx_kind_t;

    // One command as it arrives on the input port.
    typedef struct packed {
        logic                       kind;
        logic [SLOT_W-1:0]          slot;
        logic                       stereo;
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic [CHVOL_W-1:0]         chan_left_vol;
        logic [CHVOL_W-1:0]         chan_right_vol;
    } smx_in_t;

    // One drained slot as it leaves on the result port.
    typedef struct packed {
        logic [SLOT_W-1:0]       out_slot;
        logic signed [PCM_W-1:0] pcm_left;
        logic signed [PCM_W-1:0] pcm_right;
    } smx_out_t;

    // A classified command as it travels through the queue.
    typedef struct packed {
        smx_kind_t                  kind;
        logic [SLOT_W-1:0]          slot;
        logic signed [SAMPLE_W-1:0] sample_l;
        logic signed [SAMPLE_W-1:0] sample_r;
        logic [VOL_W-1:0]           vol_l;
        logic [VOL_W-1:0]           vol_r;
    } smx_op_t;

    // Arithmetic shift right by eight, then saturate to the PCM range.
    function automatic logic signed [PCM_W-1:0] to_pcm(input logic signed [ACC_W-1:0] acc);
        logic signed [SHIFTED_W-1:0] shifted;
        shifted = acc[ACC_W-1:PCM_SHIFT];
        if (shifted > SAT_HI) begin
            return PCM_MAX;
        end
        else if (shifted < SAT_LO) begin
            return PCM_MIN;
        end
        else begin
            return shifted[PCM_W-1:0];
        end
    endfunction

endpackage

[rtl/smx_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module smx_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address written in the same cycle returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/smx_front.sv]
// Front end: takes commands, holds the master volume and scales the channel volumes.
module smx_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  smx_pkg::smx_in_t             cmd,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [smx_pkg::MVOL_W-1:0]   cfg_data,
    input  logic                         clearing,
    input  logic [smx_pkg::Q_CNT_W-1:0]  q_count,
    output logic                         push,
    output smx_pkg::smx_op_t             push_data
);
    import smx_pkg::*;

    logic [MVOL_W-1:0]         master_volume_reg;
    logic                      stage_valid_reg;
    logic                      stage_valid_next;
    smx_op_t                   stage_op_reg;
    smx_op_t                   stage_op_next;
    logic                      accept;
    logic [Q_CNT_W-1:0]        pending;
    logic [CHVOL_W+MVOL_W-1:0] lvol_prod;
    logic [CHVOL_W+MVOL_W-1:0] rvol_prod;

    // The register port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_volume_reg <= MASTER_VOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            master_volume_reg <= cfg_data;
        end
    end

    // Hold off new commands while the buffer clears or the queue has no room left.
    assign pending = q_count + Q_CNT_W'(stage_valid_reg);
    assign busy    = clearing || (pending >= Q_CNT_W'(Q_DEPTH));
    assign accept  = start && !busy;

    // Effective volume is the channel volume times master volume in Q8.
    assign lvol_prod = {{MVOL_W{1'b0}}, cmd.chan_left_vol} * {{CHVOL_W{1'b0}}, master_volume_reg};
    assign rvol_prod = {{MVOL_W{1'b0}}, cmd.chan_right_vol} * {{CHVOL_W{1'b0}}, master_volume_reg};

    // Classify the command; a mono command feeds the left sample to both sides.
    always_comb
    begin
        stage_valid_next       = accept;
        stage_op_next          = stage_op_reg;
        if (accept)
        begin
            stage_op_next.kind     = smx_kind_t'(cmd.kind);
            stage_op_next.slot     = cmd.slot;
            stage_op_next.sample_l = cmd.sample_left;
            stage_op_next.sample_r = cmd.stereo ? cmd.sample_right : cmd.sample_left;
            stage_op_next.vol_l    = lvol_prod[VOL_SHIFT +: VOL_W];
            stage_op_next.vol_r    = rvol_prod[VOL_SHIFT +: VOL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_op_reg <= stage_op_next;
    end

    assign push      = stage_valid_reg;
    assign push_data = stage_op_reg;

endmodule

[rtl/smx_queue.sv]
// Short command queue that decouples the front end from the back end.
module smx_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  smx_pkg::smx_op_t            push_data,
    input  logic                        pop,
    output smx_pkg::smx_op_t            pop_data,
    output logic                        empty,
    output logic [smx_pkg::Q_CNT_W-1:0] count
);
    import smx_pkg::*;

    smx_op_t            q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Fill level follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign pop_data = q_mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

    // The front end must never overfill the queue, and the back end never pops it dry.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < Q_CNT_W'(Q_DEPTH))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command queue underflow");

endmodule

[rtl/smx_back.sv]
// Back end: clears the mix buffer after reset, then accumulates into and drains slots.
module smx_back #(
    parameter int BUFFER_DEPTH = 2048,
    parameter int IDX_W        = $clog2(BUFFER_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  smx_pkg::smx_op_t  q_data,
    output logic              pop,
    output logic              clearing,
    output logic              result_valid,
    output smx_pkg::smx_out_t result
);
    import smx_pkg::*;

    localparam int RAM_W   = 2 * ACC_W;
    localparam int MOD_W   = 17;
    localparam int MOD_STEPS = 8;

    // Clear sweep state.
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    // Read stage registers.
    logic                     a_valid_reg;
    smx_kind_t                a_kind_reg;
    logic [SLOT_W-1:0]        a_slot_reg;
    logic [IDX_W-1:0]         a_idx_reg;
    logic signed [PROD_W-1:0] a_prod_l_reg;
    logic signed [PROD_W-1:0] a_prod_r_reg;

    // Last write, kept for forwarding into a read that saw stale data.
    logic             lw_valid_reg;
    logic [IDX_W-1:0] lw_idx_reg;
    logic [RAM_W-1:0] lw_data_reg;

    // Result registers.
    logic     result_valid_reg;
    smx_out_t result_reg;

    logic                     issue;
    logic [IDX_W-1:0]         rd_idx;
    logic signed [PROD_W-1:0] prod_l;
    logic signed [PROD_W-1:0] prod_r;
    logic [RAM_W-1:0]         ram_rdata;
    logic [RAM_W-1:0]         old_data;
    logic [ACC_W-1:0]         new_l;
    logic [ACC_W-1:0]         new_r;
    logic [RAM_W-1:0]         upd_data;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [RAM_W-1:0]         ram_wdata;

    // Slot modulo buffer depth by restoring subtraction of the shifted depth.
    function automatic logic [IDX_W-1:0] slot_index(input logic [SLOT_W-1:0] s);
        logic [MOD_W-1:0] r;
        r = MOD_W'(s);
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if ((longint'(BUFFER_DEPTH) << k) < (longint'(1) << SLOT_W))
            begin
                if (r >= MOD_W'(BUFFER_DEPTH << k))
                begin
                    r = r - MOD_W'(BUFFER_DEPTH << k);
                end
            end
        end
        return r[IDX_W-1:0];
    endfunction

    assign issue  = !q_empty && !clearing_reg;
    assign pop    = issue;
    assign rd_idx = slot_index(q_data.slot);

    // Products of sample and effective volume, both sides in parallel.
    assign prod_l = q_data.sample_l * $signed({1'b0, q_data.vol_l});
    assign prod_r = q_data.sample_r * $signed({1'b0, q_data.vol_r});

    // Clear sweep: one slot per cycle from reset until the last slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(BUFFER_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        a_kind_reg   <= q_data.kind;
        a_slot_reg   <= q_data.slot;
        a_idx_reg    <= rd_idx;
        a_prod_l_reg <= prod_l;
        a_prod_r_reg <= prod_r;
    end

    // Take the previous cycle's write when it hit the same slot.
    assign old_data = (lw_valid_reg && (lw_idx_reg == a_idx_reg)) ? lw_data_reg : ram_rdata;

    assign new_l = old_data[RAM_W-1:ACC_W]
                 + {{(ACC_W-PROD_W){a_prod_l_reg[PROD_W-1]}}, a_prod_l_reg};
    assign new_r = old_data[ACC_W-1:0]
                 + {{(ACC_W-PROD_W){a_prod_r_reg[PROD_W-1]}}, a_prod_r_reg};

    // An accumulate writes the sums back; a drain writes zeros.
    always_comb
    begin
        unique case (a_kind_reg)
            KIND_ACCUM: upd_data = {new_l, new_r};
            KIND_DRAIN: upd_data = '0;
            default:    upd_data = '0;
        endcase
    end

    // Write port is shared between the clear sweep and the update stage.
    assign ram_we    = clearing_reg || a_valid_reg;
    assign ram_waddr = clearing_reg ? clr_idx_reg : a_idx_reg;
    assign ram_wdata = clearing_reg ? '0 : upd_data;

    smx_ram #(
        .WIDTH (RAM_W),
        .DEPTH (BUFFER_DEPTH),
        .ADDR_W(IDX_W)
    ) u_buf (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_idx),
        .rdata(ram_rdata)
    );

    // Forwarding and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            lw_valid_reg     <= a_valid_reg;
            result_valid_reg <= a_valid_reg && (a_kind_reg == KIND_DRAIN);
        end
    end

    always_ff @(posedge clk)
    begin
        lw_idx_reg           <= a_idx_reg;
        lw_data_reg          <= upd_data;
        result_reg.out_slot  <= a_slot_reg;
        result_reg.pcm_left  <= to_pcm(old_data[RAM_W-1:ACC_W]);
        result_reg.pcm_right <= to_pcm(old_data[ACC_W-1:0]);
    end

    assign clearing     = clearing_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result follows only a drain that was in the update stage in the cycle before.
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(a_valid_reg && (a_kind_reg == KIND_DRAIN)))
        else $error("result without a drain command");

    // No command is issued while the buffer is being cleared.
    a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |=> !a_valid_reg)
        else $error("command issued during clear sweep");

    // The clear sweep runs once after reset and never restarts.
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |=> !clearing_reg)
        else $error("clear sweep restarted");

endmodule

[rtl/stereo_mix_accumulator.sv]
// Top level of the stereo mix accumulator: front end, command queue and back end.
// A drain command passes the front stage, the queue, the read stage and the result register.
// Throughput: one command per cycle while busy is low; the back end never stalls and the queue holds four.
// Reset: the mix buffer is cleared one slot a cycle, all BUFFER_DEPTH slots, with busy high.
// Reset also sets the master volume to unity (256 in Q8); register writes are taken at once.
// Results cannot be held off: each one is on the result port for exactly one cycle.
module stereo_mix_accumulator #(
    parameter int BUFFER_DEPTH = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  smx_pkg::smx_in_t           cmd,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [smx_pkg::MVOL_W-1:0] cfg_data,
    output logic                       result_valid,
    output smx_pkg::smx_out_t          result
);
    import smx_pkg::*;

    logic               push;
    smx_op_t            push_data;
    logic               pop;
    smx_op_t            pop_data;
    logic               q_empty;
    logic [Q_CNT_W-1:0] q_count;
    logic               clearing;

    // Command intake and volume scaling.
    smx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .clearing (clearing),
        .q_count  (q_count),
        .push     (push),
        .push_data(push_data)
    );

    // Queue between the two halves.
    smx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (q_empty),
        .count    (q_count)
    );

    // Mix buffer update and drain.
    smx_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .clearing    (clearing),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule
